// ===== sv/fca_pkg.sv =====
// shared types, codes and constants of the channel aperture
package fca_pkg;

  localparam int unsigned VramAddrBits = 23;
  localparam int unsigned ApAddrBits   = 26;
  localparam int unsigned DataBits     = 32;

  localparam logic       KIND_READ  = 1'b0;
  localparam logic       KIND_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [1:0] VIEW_LINEAR = 2'd0;
  localparam logic [1:0] VIEW_MASKED = 2'd1;
  localparam logic [1:0] VIEW_PAIR   = 2'd2;
  localparam logic [1:0] VIEW_LANE   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic                  kind;
    logic [1:0]            access_size;
    logic [ApAddrBits-1:0] address;
    logic [DataBits-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [VramAddrBits-1:0] addr;
    logic [7:0]              wbyte;
  } mem_req_t;

  // index of the last byte transfer of an access
  function automatic logic [1:0] last_idx(input logic [1:0] size);
    logic [1:0] r;
    case (size)
      SIZE_BYTE: r = 2'd0;
      SIZE_HALF: r = 2'd1;
      default:   r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/fca_in_if.sv =====
// request channel: one bus access
interface fca_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [1:0]                       access_size;
  logic [fca_pkg::ApAddrBits-1:0]   address;
  logic [fca_pkg::DataBits-1:0]     write_data;

  modport source (output valid, kind, access_size, address, write_data, input ready);
  modport sink   (input valid, kind, access_size, address, write_data, output ready);
endinterface

// ===== sv/fca_out_if.sv =====
// response channel: gathered read data
interface fca_out_if;
  logic                         valid;
  logic                         ready;
  logic [fca_pkg::DataBits-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== sv/fca_ram.sv =====
// single-port synchronous ram with registered read data
module fca_ram #(
  parameter int unsigned AddrBits = 23,
  parameter int unsigned DataBits = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [DataBits-1:0] wdata_i,
  output logic [DataBits-1:0] rdata_o
);

  logic [DataBits-1:0] mem [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// ===== sv/fca_agen.sv =====
// address and data generation for one byte transfer of an access
module fca_agen (
  input  logic               run_i,
  input  fca_pkg::item_t     item_i,
  input  logic [1:0]         idx_i,
  output fca_pkg::mem_req_t  req_o
);

  localparam int unsigned AW = fca_pkg::VramAddrBits;

  logic [fca_pkg::ApAddrBits-1:0] a;
  logic [1:0]                     k;
  logic [1:0]                     sh;
  logic [1:0]                     view;
  logic [AW-1:0]                  base;
  logic [3:0]                     step;
  logic [AW-1:0]                  off;
  logic                           masked;

  always_comb begin
    // a halfword is two single bytes, the second one decoded afresh
    if (item_i.access_size == fca_pkg::SIZE_HALF) begin
      a  = item_i.address + fca_pkg::ApAddrBits'(idx_i[0]);
      k  = 2'd0;
      sh = {1'b0, ~idx_i[0]};
    end else if (item_i.access_size == fca_pkg::SIZE_BYTE) begin
      a  = item_i.address;
      k  = 2'd0;
      sh = 2'd0;
    end else begin
      a  = item_i.address;
      k  = idx_i;
      sh = ~idx_i;
    end

    view = a[25:24];
    case (view)
      fca_pkg::VIEW_PAIR: begin
        base = {a[AW-2:0], a[23]};
        step = {1'b0, k, 1'b0};
      end
      fca_pkg::VIEW_LANE: begin
        base = {a[AW-3:0], a[23:22]};
        step = {k, 2'b00};
      end
      default: begin
        base = a[AW-1:0];
        step = {2'b00, k};
      end
    endcase
    off    = base + AW'(step);
    masked = (view == fca_pkg::VIEW_MASKED) && (off[1:0] == 2'b00);

    req_o.addr  = off;
    req_o.we    = run_i && (item_i.kind == fca_pkg::KIND_WRITE) && !masked;
    req_o.re    = run_i && (item_i.kind == fca_pkg::KIND_READ);
    req_o.wbyte = item_i.write_data[{sh, 3'b000} +: 8];
  end

endmodule

// ===== sv/framebuffer_channel_aperture.sv =====
// top level: sequencer over the video memory for strided channel accesses
// accesses are taken one at a time: a new one is accepted only in idle, after the last result is issued
// the video memory moves one byte per cycle through its single port while the sequencer runs
// reset clears the sequencer and output valid; video memory is not cleared
module framebuffer_channel_aperture (
  input  logic      clk_i,
  input  logic      rst_ni,
  fca_in_if.sink    in_i,
  fca_out_if.source out_o
);

  fca_pkg::state_e   state_q, state_d;
  fca_pkg::item_t    item_q, item_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [31:0]       acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_data_q, out_data_d;
  fca_pkg::mem_req_t req;
  logic [7:0]        rdata;
  logic              run;

  assign run = (state_q == fca_pkg::ST_RUN);

  fca_agen u_agen (
    .run_i  (run),
    .item_i (item_q),
    .idx_i  (cnt_q),
    .req_o  (req)
  );

  fca_ram #(
    .AddrBits (fca_pkg::VramAddrBits),
    .DataBits (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .re_i    (req.re),
    .addr_i  (req.addr),
    .wdata_i (req.wbyte),
    .rdata_o (rdata)
  );

  assign in_i.ready      = (state_q == fca_pkg::ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    // read bytes come back in the cycle after their address, msb first
    acc_d       = pend_q ? {acc_q[23:0], rdata} : acc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    case (state_q)
      fca_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          item_d.kind        = in_i.kind;
          item_d.access_size = in_i.access_size;
          item_d.address     = in_i.address;
          item_d.write_data  = in_i.write_data;
          cnt_d              = 2'd0;
          acc_d              = '0;
          state_d            = fca_pkg::ST_RUN;
        end
      end
      fca_pkg::ST_RUN: begin
        pend_d = (item_q.kind == fca_pkg::KIND_READ);
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == fca_pkg::last_idx(item_q.access_size)) begin
          state_d = fca_pkg::ST_DRAIN;
        end
      end
      fca_pkg::ST_DRAIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_d;
          state_d     = fca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fca_pkg::ST_IDLE;
      cnt_q       <= 2'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == fca_pkg::ST_RUN && cnt_q == 2'd0))
    else $error("accepted access did not start a run");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (cnt_q <= fca_pkg::last_idx(item_q.access_size)))
    else $error("byte index beyond access size");

  a_write_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && item_q.kind == fca_pkg::KIND_WRITE) |=> !pend_q)
    else $error("write access captured read data");

  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fca_pkg::ST_DRAIN))
    else $error("result raised outside drain");

  a_no_mem_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run |-> (!req.we && !req.re))
    else $error("memory access outside run");

endmodule
